/* hdl/assert_macros.svh */
// Assertion macros shared by the intercept extractor RTL.
// Included by the top-level module, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define OIE_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define OIE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define OIE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/oie_pkg.sv */
// Types and constants for the ordered intercept extractor.
// No dependencies; used by every module of the block.
package oie_pkg;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_TAKE  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EXHAUSTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   localparam logic signed [31:0] MAX_FRAC = 32'sh7FFF_FFFF;
   localparam int FILL_W = 8;

   typedef struct packed {
      action_type         action;
      logic signed [31:0] frac_in;
      logic               is_line_in;
      logic [31:0]        ref_in;
      logic signed [31:0] limit;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] frac_out;
      logic               is_line_out;
      logic [31:0]        ref_out;
      logic [FILL_W-1:0]  fill;
   } rsp_type;

   // one stored intercept
   typedef struct packed {
      logic signed [31:0] frac;
      logic               is_line;
      logic [31:0]        handle;
   } entry_type;

   // sequencer to min unit
   typedef struct packed {
      logic start;
      logic cand_valid;
   } scan_ctl_type;

endpackage

/* hdl/oie_entry_ram.sv */
// Entry storage: intercept records plus a consumed-flag array.
// One write port each, one shared registered read port. Uses oie_pkg.
module oie_entry_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                clock,
   input  logic                ent_wr_en,
   input  logic [AW-1:0]       ent_wr_addr,
   input  oie_pkg::entry_type  ent_wr_data,
   input  logic                use_wr_en,
   input  logic [AW-1:0]       use_wr_addr,
   input  logic                use_wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output oie_pkg::entry_type  rd_entry_ff,
   output logic                rd_used_ff
);

   oie_pkg::entry_type ent_mem [DEPTH];
   logic               use_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ent_wr_en) begin
         ent_mem[ent_wr_addr] <= ent_wr_data;
      end
      if (rd_en) begin
         rd_entry_ff <= ent_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (use_wr_en) begin
         use_mem[use_wr_addr] <= use_wr_data;
      end
      if (rd_en) begin
         rd_used_ff <= use_mem[rd_addr];
      end
   end

endmodule

/* hdl/oie_min_unit.sv */
// Running-minimum compare unit: one signed compare per candidate.
// Keeps the earliest smallest unconsumed entry. Uses oie_pkg.
module oie_min_unit #(
   parameter int AW = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  oie_pkg::scan_ctl_type ctl,
   input  oie_pkg::entry_type    cand,
   input  logic                  cand_used,
   input  logic [AW-1:0]         cand_idx,
   output oie_pkg::entry_type    best_ff,
   output logic [AW-1:0]         best_idx_ff,
   output logic                  found_ff
);

   logic take;

   // strict less-than: ties keep the earlier entry, max fraction never wins
   assign take = ctl.cand_valid && !cand_used &&
                 ($signed(cand.frac) < $signed(best_ff.frac));

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         best_ff.frac <= oie_pkg::MAX_FRAC;
      end else if (take) begin
         best_ff     <= cand;
         best_idx_ff <= cand_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.start) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

endmodule

/* hdl/ordered_intercept_extractor.sv */
// Ordered intercept extractor: top level, sequencer and result register.
// Depends on oie_pkg, oie_entry_ram, oie_min_unit and assert_macros.svh.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_data) carries one word per
//    operation: clear, add entry, or take next smallest.
//  - Response channel (rsp_valid / rsp_stall / rsp_data) returns exactly one
//    word per request: status, taken entry fields and table fill.
//  - Clear and add finish without a scan; the response word is registered and
//    shows up on the cycle after the request is taken.
//  - Take-next walks the table once through a single compare unit, one entry
//    per cycle, reading the entry RAM through its registered port. The scan
//    state reads the N stored entries, the drain state compares the last
//    read, and the done state decides and registers the response word.
//  - Only one operation is in flight; req_stall is high during a scan.
//  - A pending response word sits in the output register; a new request is
//    taken as soon as that word is free or leaving in the same cycle.
//  - Holding rsp_stall freezes the response word and, through it, the
//    request side.
//  - Reset empties the table (fill zero) and drops any pending response.
//    Entry RAM contents are not cleared; only entries below fill are read.
`include "assert_macros.svh"

module ordered_intercept_extractor #(
   parameter int CAPACITY = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  oie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output oie_pkg::rsp_type rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // sequencer state
   oie_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      scan_idx_ff, scan_idx_in;
   logic signed [31:0] limit_ff, limit_in;

   // RAM read pipeline tag: data for rd_idx_ff is valid when rd_pend_ff
   logic               rd_pend_ff;
   logic [AW-1:0]      rd_idx_ff;

   // response word register
   oie_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // RAM ports
   logic               ent_wr_en;
   oie_pkg::entry_type ent_wr_data;
   logic               use_wr_en;
   logic [AW-1:0]      use_wr_addr;
   logic               use_wr_data;
   logic               rd_en;
   oie_pkg::entry_type rd_entry;
   logic               rd_used;

   // min unit
   oie_pkg::scan_ctl_type ctl;
   oie_pkg::entry_type    best;
   logic [AW-1:0]         best_idx;
   logic                  found;

   logic accept;
   logic rsp_free;
   logic is_full;
   logic scan_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // busy while a take is in progress, or while the output word is held by the receiver
   assign req_stall = (state_ff != oie_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign is_full   = (count_ff == CW'(CAPACITY));
   assign scan_last = ((CW'(scan_idx_ff) + CW'(1)) == count_ff);

   assign ent_wr_data.frac    = req_data.frac_in;
   assign ent_wr_data.is_line = req_data.is_line_in;
   assign ent_wr_data.handle  = req_data.ref_in;

   oie_entry_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock       (clock),
      .ent_wr_en   (ent_wr_en),
      .ent_wr_addr (count_ff[AW-1:0]),
      .ent_wr_data (ent_wr_data),
      .use_wr_en   (use_wr_en),
      .use_wr_addr (use_wr_addr),
      .use_wr_data (use_wr_data),
      .rd_en       (rd_en),
      .rd_addr     (scan_idx_ff),
      .rd_entry_ff (rd_entry),
      .rd_used_ff  (rd_used)
   );

   oie_min_unit #(
      .AW (AW)
   ) u_min (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .cand        (rd_entry),
      .cand_used   (rd_used),
      .cand_idx    (rd_idx_ff),
      .best_ff     (best),
      .best_idx_ff (best_idx),
      .found_ff    (found)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oie_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      limit_ff    <= limit_in;
      rd_idx_ff   <= scan_idx_ff;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_idx_in    = scan_idx_ff;
      limit_in       = limit_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      ent_wr_en      = 1'b0;
      use_wr_en      = 1'b0;
      use_wr_addr    = count_ff[AW-1:0];
      use_wr_data    = 1'b0;
      rd_en          = 1'b0;
      ctl.start      = 1'b0;
      ctl.cand_valid = rd_pend_ff;

      case (state_ff)
         oie_pkg::S_IDLE: begin
            if (accept) begin
               rsp_in.status      = oie_pkg::ST_OK;
               rsp_in.frac_out    = '0;
               rsp_in.is_line_out = 1'b0;
               rsp_in.ref_out     = '0;
               rsp_in.fill        = oie_pkg::FILL_W'(count_ff);
               case (req_data.action)
                  oie_pkg::ACT_CLEAR: begin
                     // consumed flags are rewritten on every add, so
                     // dropping the count is enough
                     count_in     = '0;
                     rsp_in.fill  = '0;
                     rsp_valid_in = 1'b1;
                  end
                  oie_pkg::ACT_ADD: begin
                     if (is_full) begin
                        rsp_in.status = oie_pkg::ST_FULL;
                     end else begin
                        ent_wr_en   = 1'b1;
                        use_wr_en   = 1'b1;
                        count_in    = count_ff + CW'(1);
                        rsp_in.fill = oie_pkg::FILL_W'(count_ff + CW'(1));
                     end
                     rsp_valid_in = 1'b1;
                  end
                  oie_pkg::ACT_TAKE: begin
                     limit_in    = req_data.limit;
                     ctl.start   = 1'b1;
                     scan_idx_in = '0;
                     state_in    = (count_ff == '0) ? oie_pkg::S_DONE : oie_pkg::S_SCAN;
                  end
                  default: begin
                     // unused action: status ok, table untouched
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         oie_pkg::S_SCAN: begin
            rd_en = 1'b1;
            if (scan_last) begin
               state_in = oie_pkg::S_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + AW'(1);
            end
         end
         oie_pkg::S_DRAIN: begin
            // last read is compared this cycle
            state_in = oie_pkg::S_DONE;
         end
         oie_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = oie_pkg::S_IDLE;
               rsp_in.fill  = oie_pkg::FILL_W'(count_ff);
               if (found && ($signed(best.frac) <= limit_ff)) begin
                  rsp_in.status      = oie_pkg::ST_OK;
                  rsp_in.frac_out    = best.frac;
                  rsp_in.is_line_out = best.is_line;
                  rsp_in.ref_out     = best.handle;
                  use_wr_en          = 1'b1;
                  use_wr_addr        = best_idx;
                  use_wr_data        = 1'b1;
               end else begin
                  rsp_in.status      = oie_pkg::ST_EXHAUSTED;
                  rsp_in.frac_out    = '0;
                  rsp_in.is_line_out = 1'b0;
                  rsp_in.ref_out     = '0;
               end
            end
         end
         default: begin
            state_in = oie_pkg::S_IDLE;
         end
      endcase
   end

   // table never overfills
   `OIE_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY))
   // scan address stays inside the stored entries
   `OIE_ASSERT_IMPLY(a_scan_in_range, clock, reset,
      state_ff == oie_pkg::S_SCAN, CW'(scan_idx_ff) < count_ff)
   // a picked entry is never the reserved maximum fraction
   `OIE_ASSERT_IMPLY(a_pick_not_max, clock, reset,
      state_ff == oie_pkg::S_DONE && found, best.frac != oie_pkg::MAX_FRAC)
   // finishing a take always posts a response word
   `OIE_ASSERT_NEXT(a_done_posts, clock, reset,
      state_ff == oie_pkg::S_DONE && state_in == oie_pkg::S_IDLE, rsp_valid_ff)

endmodule

/* test/ordered_intercept_extractor_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for ordered_intercept_extractor: clear/add/take words in, one answer out.
// Depends on oie_pkg (word types, codes) and the RTL under hdl/; keeps its own table model.
module ordered_intercept_extractor_tb;

   localparam int TABLE_DEPTH = 128;
   localparam int RANDOM_OPS  = 400;
   // Watchdog bound: the slowest sane run, every word a full scan plus sender
   // gaps and receiver stalls, stays well under it, with a wide margin.
   localparam int CYCLE_LIMIT  = 1_000_000;
   // Longest scan plus margin; waited out once the last answer is in.
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 20;
   localparam int HOLDOFF_LEN  = 400;
   localparam logic [1:0]         ACT_UNUSED = 2'd3;
   localparam logic signed [31:0] FRAC_MIN   = 32'sh8000_0000;

   typedef enum {RX_FREE, RX_COIN, RX_MOSTLY, RX_RARE} rx_mode_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   oie_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   oie_pkg::rsp_type rsp_data;

   ordered_intercept_extractor #(.CAPACITY(TABLE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the intercept table. Only entries below tbl_count are read.
   // ---------------------------------------------------------------------
   logic signed [31:0]     tbl_frac   [TABLE_DEPTH];
   logic                   tbl_line   [TABLE_DEPTH];
   logic [31:0]            tbl_handle [TABLE_DEPTH];
   bit [TABLE_DEPTH-1:0]   tbl_taken;
   int                     tbl_count;

   oie_pkg::req_type queued_ops[$];        // words waiting for the driver
   oie_pkg::rsp_type expected_answers[$];  // predicted answers, oldest first
   int      total_ops;
   int      ops_accepted;
   int      answers_seen;
   int      mismatches;
   int      cycle_count;
   bit      word_taken;           // req handshake at the last rising edge

   // sender burst shaping
   int burst_left;
   int gap_left;

   // receiver stall pattern
   rx_mode_type stall_mode;
   int          mode_left;
   int          holdoff_left;
   bit          holdoff_done;
   logic [1:0]  rx_phase;

   // Apply one word to the shadow table and return the answer it must produce.
   function automatic oie_pkg::rsp_type apply_table_op(input oie_pkg::req_type op);
      oie_pkg::rsp_type   ans;
      logic signed [31:0] best;
      int                 pick;
      bit                 found;
      ans        = '0;
      ans.status = oie_pkg::ST_OK;
      case (op.action)
         oie_pkg::ACT_CLEAR: begin
            tbl_count = 0;
            tbl_taken = '0;
         end
         oie_pkg::ACT_ADD: begin
            if (tbl_count >= TABLE_DEPTH) begin
               ans.status = oie_pkg::ST_FULL;
            end else begin
               tbl_frac[tbl_count]   = op.frac_in;
               tbl_line[tbl_count]   = op.is_line_in;
               tbl_handle[tbl_count] = op.ref_in;
               tbl_taken[tbl_count]  = 1'b0;
               tbl_count++;
            end
         end
         oie_pkg::ACT_TAKE: begin
            // strict less-than: earliest entry wins ties, and an entry at
            // the maximum fraction can never beat the starting value
            best  = oie_pkg::MAX_FRAC;
            found = 1'b0;
            pick  = 0;
            for (int i = 0; i < tbl_count; i++) begin
               if (!tbl_taken[i] && $signed(tbl_frac[i]) < $signed(best)) begin
                  best  = tbl_frac[i];
                  pick  = i;
                  found = 1'b1;
               end
            end
            if (!found || $signed(best) > $signed(op.limit)) begin
               ans.status = oie_pkg::ST_EXHAUSTED;
            end else begin
               tbl_taken[pick]  = 1'b1;
               ans.frac_out     = tbl_frac[pick];
               ans.is_line_out  = tbl_line[pick];
               ans.ref_out      = tbl_handle[pick];
            end
         end
         default: ;  // unused action: no change, ok status
      endcase
      ans.fill = 8'(tbl_count);
      return ans;
   endfunction

   function automatic oie_pkg::req_type make_op(input oie_pkg::action_type act,
                                                input logic signed [31:0] f,
                                                input logic k, input logic [31:0] h,
                                                input logic signed [31:0] lim);
      oie_pkg::req_type w;
      w.action     = act;
      w.frac_in    = f;
      w.is_line_in = k;
      w.ref_in     = h;
      w.limit      = lim;
      return w;
   endfunction

   // Fractions: extremes, a narrow band that makes ties likely, and full range.
   function automatic logic signed [31:0] pick_frac();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = oie_pkg::MAX_FRAC;
         1:       v = FRAC_MIN;
         2, 3, 4: v = (32'($urandom_range(0, 8)) - 32'd4) << 16;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Limits lean open so that most takes succeed, with some tight ones.
   function automatic logic signed [31:0] pick_limit();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = oie_pkg::MAX_FRAC;
         4:          v = FRAC_MIN;
         5, 6:       v = (32'($urandom_range(0, 8)) - 32'd4) << 16;
         default:    v = $urandom;
      endcase
      return v;
   endfunction

   function automatic oie_pkg::req_type rand_op(input oie_pkg::action_type act);
      return make_op(act, pick_frac(), 1'($urandom_range(0, 1)), $urandom, pick_limit());
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge. The answer is
   // checked before a new request is predicted, since a word may leave in
   // the same cycle the next one is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      oie_pkg::rsp_type want;
      word_taken = !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         answers_seen++;
         if (expected_answers.size() == 0) begin
            $error("answer word with no request outstanding");
            mismatches++;
         end else begin
            want = expected_answers.pop_front();
            check_field("status",      32'(want.status),      32'(rsp_data.status));
            check_field("frac_out",    32'(want.frac_out),    32'(rsp_data.frac_out));
            check_field("is_line_out", 32'(want.is_line_out), 32'(rsp_data.is_line_out));
            check_field("ref_out",     32'(want.ref_out),     32'(rsp_data.ref_out));
            check_field("fill",        32'(want.fill),        32'(rsp_data.fill));
         end
      end
      if (word_taken) begin
         ops_accepted++;
         expected_answers.push_back(apply_table_op(req_data));
      end
   end

   // ---------------------------------------------------------------------
   // Driver: bursts of words with random gaps. A word stays put until taken;
   // valid is decided without looking at req_stall.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      logic             next_valid;
      oie_pkg::req_type next_word;
      next_valid = req_valid;
      next_word  = req_data;
      if (!reset) begin
         if (word_taken) next_valid = 1'b0;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (queued_ops.size() != 0) begin
               next_word  = queued_ops.pop_front();
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_word;
   end

   // ---------------------------------------------------------------------
   // Receiver: stall modes, each held for a random length drawn into mode_left,
   // plus one long hold-off so the block backs up into req_stall.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      logic hold;
      hold = 1'b0;
      rx_phase++;
      if (!holdoff_done && answers_seen >= 30) begin
         holdoff_left = HOLDOFF_LEN;
         holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         hold = 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            RX_FREE:   hold = 1'b0;
            RX_COIN:   hold = 1'($urandom_range(0, 1));
            RX_MOSTLY: hold = (rx_phase != 2'd0);
            default:   hold = ($urandom_range(0, 7) == 0);
         endcase
      end
      rsp_stall <= hold;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ordered_intercept_extractor_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int n;
      int roll;
      bit first_seq;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      tbl_count    = 0;
      tbl_taken    = '0;
      ops_accepted = 0;
      answers_seen = 0;
      mismatches   = 0;
      cycle_count  = 0;
      word_taken   = 1'b0;
      burst_left   = 1;
      gap_left     = 0;
      stall_mode   = RX_FREE;
      mode_left    = 0;
      holdoff_left = 0;
      holdoff_done = 1'b0;
      rx_phase     = '0;
      first_seq    = 1'b1;

      // Directed: empty-table cases, unused action, the extremes of the
      // fraction, a tie, limit at both ends, the max-fraction entry as the
      // first candidate, then clear.
      queued_ops.push_back(make_op(oie_pkg::ACT_TAKE, 32'sd0, 1'b0, 32'h0,
                                   oie_pkg::MAX_FRAC));
      queued_ops.push_back(make_op(oie_pkg::ACT_CLEAR, 32'sd0, 1'b0, 32'h0, 32'sd0));
      queued_ops.push_back(make_op(oie_pkg::action_type'(ACT_UNUSED), oie_pkg::MAX_FRAC,
                                   1'b1, 32'hFFFF_FFFF, FRAC_MIN));
      queued_ops.push_back(make_op(oie_pkg::ACT_ADD, oie_pkg::MAX_FRAC, 1'b1,
                                   32'hFFFF_FFFF, 32'sd0));
      queued_ops.push_back(make_op(oie_pkg::ACT_TAKE, 32'sd0, 1'b0, 32'h0,
                                   oie_pkg::MAX_FRAC));
      queued_ops.push_back(make_op(oie_pkg::ACT_ADD,  FRAC_MIN, 1'b0, 32'h0, 32'sd0));
      queued_ops.push_back(make_op(oie_pkg::ACT_ADD,  32'sd0, 1'b1, 32'hA5A5_5A5A, 32'sd0));
      queued_ops.push_back(make_op(oie_pkg::ACT_ADD,  32'sd0, 1'b0, 32'h5A5A_A5A5, 32'sd0));
      queued_ops.push_back(make_op(oie_pkg::ACT_ADD,  -32'sd1, 1'b1, 32'h0000_0001, 32'sd0));
      queued_ops.push_back(make_op(oie_pkg::ACT_TAKE, 32'sd0, 1'b0, 32'h0, FRAC_MIN));
      queued_ops.push_back(make_op(oie_pkg::ACT_TAKE, 32'sd0, 1'b0, 32'h0, FRAC_MIN));
      queued_ops.push_back(make_op(oie_pkg::ACT_TAKE, 32'sd0, 1'b0, 32'h0, -32'sd1));
      queued_ops.push_back(make_op(oie_pkg::ACT_TAKE, 32'sd0, 1'b0, 32'h0, 32'sd0));
      queued_ops.push_back(make_op(oie_pkg::ACT_TAKE, 32'sd0, 1'b0, 32'h0,
                                   oie_pkg::MAX_FRAC));
      queued_ops.push_back(make_op(oie_pkg::ACT_TAKE, 32'sd0, 1'b0, 32'h0,
                                   oie_pkg::MAX_FRAC));
      queued_ops.push_back(make_op(oie_pkg::action_type'(ACT_UNUSED), 32'sd0, 1'b0,
                                   32'h0, 32'sd0));
      queued_ops.push_back(make_op(oie_pkg::ACT_CLEAR, 32'sd0, 1'b0, 32'h0, 32'sd0));
      queued_ops.push_back(make_op(oie_pkg::ACT_TAKE,  32'sd0, 1'b0, 32'h0,
                                   oie_pkg::MAX_FRAC));

      // Random: mostly clear/add/take sequences with random content, now
      // and then a run past capacity, and some noise with any action.
      // The first sequence always overfills the table.
      n = queued_ops.size() + RANDOM_OPS;
      while (queued_ops.size() < n) begin
         roll      = first_seq ? 0 : $urandom_range(0, 15);
         first_seq = 1'b0;
         if (roll == 0) begin
            queued_ops.push_back(rand_op(oie_pkg::ACT_CLEAR));
            repeat (TABLE_DEPTH + $urandom_range(1, 4))
               queued_ops.push_back(rand_op(oie_pkg::ACT_ADD));
            repeat ($urandom_range(3, 10)) queued_ops.push_back(rand_op(oie_pkg::ACT_TAKE));
         end else if (roll <= 2) begin
            repeat ($urandom_range(1, 8))
               queued_ops.push_back(rand_op(oie_pkg::action_type'(2'($urandom_range(0, 3)))));
         end else begin
            if ($urandom_range(0, 3) != 0) queued_ops.push_back(rand_op(oie_pkg::ACT_CLEAR));
            roll = $urandom_range(1, 12);
            repeat (roll) queued_ops.push_back(rand_op(oie_pkg::ACT_ADD));
            repeat ($urandom_range(1, roll + 2)) begin
               if ($urandom_range(0, 4) == 0) queued_ops.push_back(rand_op(oie_pkg::ACT_ADD));
               queued_ops.push_back(rand_op(oie_pkg::ACT_TAKE));
            end
         end
      end
      total_ops = queued_ops.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // everything sent, every answer in, then a quiet stretch that would
      // catch any stray extra word
      while (ops_accepted < total_ops) @(negedge clock);
      while (expected_answers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("ordered_intercept_extractor_tb: done, clean");
      end else begin
         $display("ordered_intercept_extractor_tb: done, errors");
      end
      $finish;
   end

endmodule
